[rtl/spq_pkg.sv]
package spq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned OCC_W = 5;
  localparam int unsigned VAL_W = 32;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

  typedef struct packed {
    logic                    ins;
    logic                    deq;
    logic signed [VAL_W-1:0] value;
  } spq_ctl_t;

endpackage

[rtl/spq_cell.sv]
module spq_cell (
  input  logic                             clk,
  input  spq_pkg::spq_ctl_t                ctl,
  input  logic                             occ,
  input  logic                             prev_lt,
  input  logic signed [spq_pkg::VAL_W-1:0] prev_data,
  input  logic signed [spq_pkg::VAL_W-1:0] next_data,
  output logic                             lt,
  output logic signed [spq_pkg::VAL_W-1:0] data
);

  logic signed [spq_pkg::VAL_W-1:0] data_r;
  logic signed [spq_pkg::VAL_W-1:0] data_nxt;

  // held value is strictly below the incoming one: it stays put on insert
  assign lt   = occ && (data_r < ctl.value);
  assign data = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (lt) begin
        data_nxt = data_r;
      end else if (prev_lt) begin
        data_nxt = ctl.value;
      end else begin
        data_nxt = prev_data;
      end
    end else if (ctl.deq) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

[rtl/sorted_priority_queue.sv]
// Result strobe comes in the cycle after start is taken.
// Throughput: one command per cycle; every cell compares and shifts in parallel,
// so busy stays low.
// Reset (rst_n low, synchronous) empties the queue; stored values are undefined
// until written. Results cannot be stalled by the receiver.
module sorted_priority_queue (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_command,
  input  logic signed [spq_pkg::VAL_W-1:0] in_value_in,
  output logic                             out_valid,
  output logic signed [spq_pkg::VAL_W-1:0] out_value_out,
  output logic                             out_value_valid,
  output logic                             out_empty_error,
  output logic                             out_full_error,
  output logic        [spq_pkg::OCC_W-1:0] out_occupancy
);

  logic                             accept;
  logic                             is_full;
  logic                             is_empty;
  spq_pkg::spq_ctl_t                ctl;
  logic [spq_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                             valid_r;
  logic signed [spq_pkg::VAL_W-1:0] vout_r, vout_nxt;
  logic                             vvalid_r, vvalid_nxt;
  logic                             empty_r, empty_nxt;
  logic                             full_r, full_nxt;
  logic [spq_pkg::DEPTH-1:0]        occ;
  logic [spq_pkg::DEPTH-1:0]        lt;
  logic signed [spq_pkg::VAL_W-1:0] data [spq_pkg::DEPTH];

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (cnt_r == spq_pkg::CNT_W'(spq_pkg::DEPTH));
  assign is_empty = (cnt_r == '0);

  assign ctl.ins   = accept && (in_command == spq_pkg::CMD_INSERT) && !is_full;
  assign ctl.deq   = accept && (in_command == spq_pkg::CMD_DEQUEUE) && !is_empty;
  assign ctl.value = in_value_in;

  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    logic                             p_lt;
    logic signed [spq_pkg::VAL_W-1:0] p_data;
    logic signed [spq_pkg::VAL_W-1:0] n_data;

    assign occ[i] = (cnt_r > spq_pkg::CNT_W'(i));

    if (i == 0) begin : g_head
      assign p_lt   = 1'b1;
      assign p_data = '0;
    end else begin : g_body
      assign p_lt   = lt[i-1];
      assign p_data = data[i-1];
    end

    if (i == spq_pkg::DEPTH - 1) begin : g_tail
      assign n_data = '0;
    end else begin : g_mid
      assign n_data = data[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ[i]),
      .prev_lt   (p_lt),
      .prev_data (p_data),
      .next_data (n_data),
      .lt        (lt[i]),
      .data      (data[i])
    );
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    vout_nxt   = '0;
    vvalid_nxt = 1'b0;
    empty_nxt  = 1'b0;
    full_nxt   = 1'b0;
    if (ctl.ins) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (ctl.deq) begin
      cnt_nxt    = cnt_r - 1'b1;
      vout_nxt   = data[0];
      vvalid_nxt = 1'b1;
    end
    if (accept && (in_command == spq_pkg::CMD_INSERT) && is_full) begin
      full_nxt = 1'b1;
    end
    if (accept && (in_command == spq_pkg::CMD_DEQUEUE) && is_empty) begin
      empty_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    vout_r   <= vout_nxt;
    vvalid_r <= vvalid_nxt;
    empty_r  <= empty_nxt;
    full_r   <= full_nxt;
  end

  assign out_valid       = valid_r;
  assign out_value_out   = vout_r;
  assign out_value_valid = vvalid_r;
  assign out_empty_error = empty_r;
  assign out_full_error  = full_r;
  assign out_occupancy   = spq_pkg::OCC_W'(cnt_r);

endmodule

[rtl/spq_checker.sv]
module spq_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_valid,
  input logic signed [spq_pkg::VAL_W-1:0] out_value_out,
  input logic                             out_value_valid,
  input logic                             out_empty_error,
  input logic                             out_full_error,
  input logic        [spq_pkg::OCC_W-1:0] out_occupancy
);

  // one result beat for every accepted command, in the next cycle
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_valid == $past(start && !busy)))
    else $error("result beat does not match accepted command");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_value_valid, out_empty_error, out_full_error}) <= 1)
    else $error("more than one status flag set");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_error |-> (out_occupancy == '0) && (out_value_out == '0))
    else $error("empty dequeue with data or occupancy");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_error |-> (out_occupancy == spq_pkg::OCC_FULL))
    else $error("dropped insert while not full");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_value_out   (out_value_out),
  .out_value_valid (out_value_valid),
  .out_empty_error (out_empty_error),
  .out_full_error  (out_full_error),
  .out_occupancy   (out_occupancy)
);
